### rtl/srrip_hp_pkg.sv
// Package: sizes, opcodes and shared types for the SRRIP victim block with hot-row pinning.
`default_nettype none
package srrip_hp_pkg;

  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int MAX_RRPV = 3;

  localparam int RRPV_W = $clog2(MAX_RRPV + 1);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WIDX_W = $clog2(NUM_WAYS);
  localparam int ROW_W  = NUM_WAYS * RRPV_W;

  localparam int OP_W     = 2;
  localparam int SETF_W   = 11;
  localparam int WAYF_W   = 4;
  localparam int LIM_W    = 5;
  localparam int MASK_W   = 16;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 8;

  typedef enum logic [OP_W-1:0] {
    OP_VICTIM = 2'd0,
    OP_HIT    = 2'd1,
    OP_FILL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] row_t;

  typedef struct packed {
    op_t                op;
    logic [SET_W-1:0]   set_index;
    logic [WAYF_W-1:0]  way_index;
    logic [LIM_W-1:0]   way_limit;
    logic [NUM_WAYS-1:0] qmask;
    logic [NUM_WAYS-1:0] hmask;
    logic               hot;
  } req_t;

  typedef struct packed {
    row_t                row;
    logic [NUM_WAYS-1:0] open;
    logic [NUM_WAYS-1:0] pinned;
    logic                found;
    logic [WIDX_W-1:0]   first;
    logic                any_free;
    logic [RRPV_W-1:0]   best;
  } scan_t;

endpackage
`default_nettype wire

### rtl/srrip_victim_with_hot_row_pinning_top.sv
// Top level: SRRIP replacement state with hot-row pinning, one set row per RAM word.
//
//  channel  | dir | tuser | tdata
//  s_*      | in  | op    | set_index, way_index, way_limit, hot_quarter_mask,
//           |     |       | hot_half_mask, hot_rows_present
//  m_*      | out | -     | victim_way, victim_found
//
// Each word passes through RAM read, scan of the row and write back of the row.
// One RAM row port per direction; no overlap between words.
// After reset a clearing pass writes all 2048 rows, s_tready low.
// Results sit in an output register; a victim result waits in write back
// while the previous result is still held and m_tready is low,
// hit and fill words never stall.
`default_nettype none
module srrip_victim_with_hot_row_pinning_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [10:0] set_index, [14:11] way_index, [19:15] way_limit,
  // [35:20] hot_quarter_mask, [51:36] hot_half_mask, [52] hot_rows_present
  input  wire logic [srrip_hp_pkg::IN_W-1:0] s_tdata,
  // [1:0] op
  input  wire logic [srrip_hp_pkg::OP_W-1:0] s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [3:0] victim_way, [4] victim_found
  output logic [srrip_hp_pkg::OUT_W-1:0]     m_tdata
);
  import srrip_hp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WR    = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [SET_W-1:0] clr_addr;
  req_t  req;
  scan_t scan, scan_next;
  logic  out_found;
  logic [WAYF_W-1:0] out_way;

  logic accept, go;
  logic ram_we, ram_re;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;
  row_t rd_row, wr_row;
  logic res_found;
  logic [WAYF_W-1:0] res_way;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (req.op != OP_VICTIM) || !m_tvalid || m_tready;

  assign ram_re    = accept;
  assign ram_raddr = SET_W'(s_tdata[SETF_W-1:0]);
  assign rd_row    = ram_rdata;

  srrip_hp_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan: quarter pinning, first way at max, largest value among free ways.
  always_comb begin
    logic [MAX_RRPV:0] has;
    logic [NUM_WAYS-1:0] free;
    scan_next = '0;
    has = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      scan_next.open[w] = (w == 0) || (req.way_limit > LIM_W'(w));
      scan_next.row[w]  = (req.op == OP_VICTIM && scan_next.open[w] && req.qmask[w]) ?
                          '0 : rd_row[w];
      scan_next.pinned[w] = scan_next.open[w] && req.hot && req.hmask[w];
    end
    free = scan_next.open & ~scan_next.pinned;
    scan_next.any_free = |free;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (scan_next.open[w] && scan_next.row[w] == RRPV_W'(MAX_RRPV)) begin
        scan_next.found = 1'b1;
        scan_next.first = WIDX_W'(w);
      end
      if (free[w]) begin
        has[scan_next.row[w]] = 1'b1;
      end
    end
    for (int v = 0; v <= MAX_RRPV; v++) begin
      if (has[v]) begin
        scan_next.best = RRPV_W'(v);
      end
    end
  end

  // Write back: age the row or apply hit/fill, pick the victim.
  always_comb begin
    logic [RRPV_W-1:0] gain;
    logic              chosen;
    wr_row    = scan.row;
    res_found = 1'b0;
    res_way   = '0;
    chosen    = 1'b0;
    gain      = RRPV_W'(MAX_RRPV) - scan.best;
    case (req.op)
      OP_HIT, OP_FILL: begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (32'(req.way_index) == w) begin
            wr_row[w] = (req.op == OP_HIT) ? '0 : RRPV_W'(MAX_RRPV - 1);
          end
        end
      end
      OP_VICTIM: begin
        if (scan.found) begin
          res_found = 1'b1;
          res_way   = WAYF_W'(scan.first);
        end else if (!scan.any_free) begin
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (scan.open[w]) begin
              wr_row[w] = '0;
            end
          end
        end else begin
          res_found = 1'b1;
          for (int w = 0; w < NUM_WAYS; w++) begin
            if (scan.open[w]) begin
              if (scan.pinned[w]) begin
                wr_row[w] = '0;
              end else begin
                wr_row[w] = scan.row[w] + gain;
                if (!chosen && scan.row[w] == scan.best) begin
                  chosen  = 1'b1;
                  res_way = WAYF_W'(w);
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req.set_index;
    ram_wdata = wr_row;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = {NUM_WAYS{RRPV_W'(MAX_RRPV)}};
    end else if (state == S_WR && go && req.op != OP_NONE) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == SET_W'(NUM_SETS - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  state_next = S_WR;
      S_WR:    if (go) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_WR && go && req.op == OP_VICTIM) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.op        <= op_t'(s_tuser);
      req.set_index <= SET_W'(s_tdata[10:0]);
      req.way_index <= s_tdata[14:11];
      req.way_limit <= s_tdata[19:15];
      req.qmask     <= NUM_WAYS'(s_tdata[35:20]);
      req.hmask     <= NUM_WAYS'(s_tdata[51:36]);
      req.hot       <= s_tdata[52];
    end
    if (state == S_SCAN) begin
      scan <= scan_next;
    end
    if (state == S_WR && go && req.op == OP_VICTIM) begin
      out_way   <= res_way;
      out_found <= res_found;
    end
  end

  assign m_tdata = {3'b000, out_found, out_way};

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !s_tready)
    else $error("input ready during clearing pass");
  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WR))
    else $error("row write outside clear or write back");
  a_no_victim_way_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[4]) |-> (m_tdata[3:0] == 4'd0))
    else $error("pinned result with nonzero way");
`endif

endmodule
`default_nettype wire

### rtl/srrip_hp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module srrip_hp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### test/srrip_hp_checker.sv
// Checker: tracks per-set RRPV rows, predicts victim words and compares the output stream.
`timescale 1ns / 1ps
module srrip_hp_checker
  import srrip_hp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [OP_W-1:0]  s_tuser,
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int               errors,
  output int               pending,
  output int               victims_checked,
  output int               none_evictable
);

  typedef struct packed {
    row_t              row;
    logic [WIDX_W-1:0] way;
    logic              found;
  } victim_pick_t;

  typedef struct packed {
    logic [WIDX_W-1:0] way;
    logic              found;
  } victim_word_t;

  row_t         rrpv_rows [NUM_SETS];
  victim_word_t victims_due [$];

  function automatic victim_pick_t choose_victim(row_t row, logic [LIM_W-1:0] limit,
                                                 logic [MASK_W-1:0] qmask,
                                                 logic [MASK_W-1:0] hmask, logic hot);
    victim_pick_t      res;
    int                n;
    bit                free_seen;
    logic [RRPV_W-1:0] best;
    logic [RRPV_W-1:0] gain;
    n = (limit == 0) ? 1 : ((int'(limit) > NUM_WAYS) ? NUM_WAYS : int'(limit));
    res.row = row;
    res.way = '0;
    res.found = 1'b0;
    for (int w = 0; w < n; w++)
      if (qmask[w]) res.row[w] = '0;
    for (int w = 0; w < n; w++)
      if (!res.found && res.row[w] == RRPV_W'(MAX_RRPV)) begin
        res.found = 1'b1;
        res.way = WIDX_W'(w);
      end
    if (res.found) return res;
    free_seen = 1'b0;
    best = '0;
    for (int w = 0; w < n; w++)
      if (!(hot && hmask[w])) begin
        if (!free_seen || res.row[w] > best) best = res.row[w];
        free_seen = 1'b1;
      end
    if (!free_seen) begin
      // every open way pinned: one aging round clears them all
      for (int w = 0; w < n; w++) res.row[w] = '0;
      return res;
    end
    gain = RRPV_W'(MAX_RRPV) - best;
    for (int w = 0; w < n; w++) begin
      if (hot && hmask[w]) begin
        res.row[w] = '0;
      end else begin
        res.row[w] = res.row[w] + gain;
        if (!res.found && res.row[w] == RRPV_W'(MAX_RRPV)) begin
          res.found = 1'b1;
          res.way = WIDX_W'(w);
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    victim_word_t      got;
    victim_word_t      want;
    victim_pick_t      pick;
    op_t               op;
    int                set_no;
    logic [WAYF_W-1:0] way_no;
    if (rst) begin
      for (int s = 0; s < NUM_SETS; s++)
        for (int w = 0; w < NUM_WAYS; w++) rrpv_rows[s][w] = RRPV_W'(MAX_RRPV);
      victims_due.delete();
      errors = 0;
      victims_checked = 0;
      none_evictable = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.way = m_tdata[3:0];
        got.found = m_tdata[4];
        if (victims_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word way=%0d found=%0b", $time, got.way,
                   got.found);
        end else begin
          want = victims_due.pop_front();
          victims_checked++;
          if (!want.found) none_evictable++;
          if (got.way !== want.way) begin
            errors++;
            $display("%0t: victim_way expected %0d actual %0d", $time, want.way, got.way);
          end
          if (got.found !== want.found) begin
            errors++;
            $display("%0t: victim_found expected %0b actual %0b", $time, want.found,
                     got.found);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        op = op_t'(s_tuser);
        set_no = int'(s_tdata[10:0]) % NUM_SETS;
        way_no = s_tdata[14:11];
        case (op)
          OP_HIT: begin
            if (int'(way_no) < NUM_WAYS) rrpv_rows[set_no][way_no] = '0;
          end
          OP_FILL: begin
            if (int'(way_no) < NUM_WAYS) rrpv_rows[set_no][way_no] = RRPV_W'(MAX_RRPV - 1);
          end
          OP_VICTIM: begin
            pick = choose_victim(rrpv_rows[set_no], s_tdata[19:15], s_tdata[35:20],
                                 s_tdata[51:36], s_tdata[52]);
            rrpv_rows[set_no] = pick.row;
            victims_due.push_back('{way: pick.way, found: pick.found});
          end
          default: ;
        endcase
      end
    end
    pending = victims_due.size();
  end

endmodule

### test/srrip_victim_with_hot_row_pinning_top_tb.sv
// Testbench top: drives request words and result backpressure, reports the verdict.
`timescale 1ns / 1ps
module srrip_victim_with_hot_row_pinning_top_tb;
  import srrip_hp_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_WORDS = 2000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]  s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int errors;
  int pending;
  int victims_checked;
  int none_evictable;
  int cycles = 0;
  int words_sent = 0;
  bit steady = 1'b0;

  always #6 clk = ~clk;

  srrip_victim_with_hot_row_pinning_top i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  srrip_hp_checker i_checker (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .errors(errors),
    .pending(pending),
    .victims_checked(victims_checked),
    .none_evictable(none_evictable)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= steady || ($urandom_range(99) >= 22);

  task automatic send_word(op_t op, logic [10:0] set_no, logic [3:0] way_no,
                           logic [4:0] limit, logic [15:0] qmask, logic [15:0] hmask,
                           logic hot);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b000, hot, hmask, qmask, limit, way_no, set_no};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'($urandom);
      2: return 16'($urandom & $urandom & $urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  initial begin
    op_t         op;
    logic [10:0] set_no;
    logic [4:0]  limit;
    int          counted;
    int          i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed
    send_word(OP_VICTIM, 11'd0, 4'd0, 5'd16, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd1, 4'd0, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd2, 4'd0, 5'd31, 16'h0001, 16'h0000, 1'b0);
    send_word(OP_HIT, 11'd3, 4'd0, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_FILL, 11'd3, 4'd1, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_NONE, 11'd3, 4'd1, 5'd2, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(OP_VICTIM, 11'd3, 4'd0, 5'd2, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd4, 4'd0, 5'd16, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(OP_VICTIM, 11'd5, 4'd0, 5'd16, 16'hFFFF, 16'hFFFF, 1'b1);
    send_word(OP_VICTIM, 11'd5, 4'd0, 5'd16, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd6, 4'd0, 5'd4, 16'h0001, 16'h0003, 1'b1);
    send_word(OP_FILL, 11'd7, 4'd0, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_HIT, 11'd7, 4'd1, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd7, 4'd0, 5'd2, 16'h0000, 16'h0001, 1'b1);
    send_word(OP_FILL, 11'd2047, 4'd15, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_HIT, 11'd2047, 4'd14, 5'd0, 16'h0000, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd2047, 4'd0, 5'd16, 16'h3FFF, 16'h0000, 1'b0);
    send_word(OP_VICTIM, 11'd2047, 4'd0, 5'd16, 16'h7FFF, 16'h8000, 1'b1);
    send_word(OP_VICTIM, 11'd2047, 4'd0, 5'd16, 16'hFFFF, 16'h7FFF, 1'b1);
    send_word(OP_VICTIM, 11'd1024, 4'd0, 5'd1, 16'h0000, 16'h0001, 1'b1);
    send_word(OP_VICTIM, 11'd1024, 4'd0, 5'd1, 16'h0001, 16'h0001, 1'b0);

    // hold off until the block has drained
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);

    counted = 0;
    i = 0;
    while (counted < RANDOM_WORDS) begin
      steady = (i >= 800 && i < 1100);
      if (i == 1200) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
      end
      case ($urandom_range(99)) inside
        [0:44]:  op = OP_VICTIM;
        [45:69]: op = OP_HIT;
        [70:91]: op = OP_FILL;
        default: op = OP_NONE;
      endcase
      // mostly a few busy sets so the rows age deeply
      if ($urandom_range(3) == 0) set_no = 11'($urandom_range(2047));
      else set_no = 11'($urandom_range(7) + ($urandom_range(1) ? 2040 : 0));
      if ($urandom_range(9) == 0) limit = 5'($urandom_range(31));
      else limit = 5'($urandom_range(16, 1));
      send_word(op, set_no, 4'($urandom_range(15)), limit, rand_mask(), rand_mask(),
                1'($urandom_range(1)));
      if (op != OP_NONE) counted++;
      i++;
    end
    steady = 1'b0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);

    $display("sent %0d request words: hit, fill, idle op and victim searches over all limits",
             words_sent);
    $display("checked %0d victim words, %0d with every open way pinned",
             victims_checked, none_evictable);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/srrip_hp_pkg.sv
rtl/srrip_hp_ram.sv
rtl/srrip_victim_with_hot_row_pinning_top.sv
test/srrip_hp_checker.sv
test/srrip_victim_with_hot_row_pinning_top_tb.sv
